// ===== rtl/pwg_pkg.sv =====
// pwg_pkg: shared types and constants for the pairing window gate
// no dependencies
`timescale 1ns / 1ps
package pwg_pkg;
  localparam int KIND_W = 4;
  localparam int CONN_W = 8;
  localparam int BYTE_W = 8;
  localparam int PK_IN_W = 32;
  localparam int PK_W = 20;
  localparam int LEN_W = 24;
  localparam int ATT_W = 3;
  localparam int ST_W = 3;
  localparam int EVK_W = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [LEN_W-1:0] LEN_RESET = 24'd60000;
  localparam logic [ATT_W-1:0] ATT_RESET = 3'd3;
  localparam logic [PK_IN_W-1:0] PASSKEY_LIMIT = 32'd999999;
  localparam logic [BYTE_W-1:0] AUTH_SC_BIT = 8'h08;
  localparam logic [BYTE_W-1:0] IO_KBD_ONLY = 8'h02;
  localparam logic [BYTE_W-1:0] IO_KBD_DISPLAY = 8'h04;
  localparam logic [BYTE_W-1:0] KEY_BYTES = 8'd16;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ATT = 1'd1;

  typedef enum logic [KIND_W-1:0] {
    K_INIT = 4'd0, K_OPEN = 4'd1, K_CLOSE = 4'd2, K_TICK = 4'd3,
    K_REQUEST = 4'd4, K_PASSKEY = 4'd5, K_FAIL = 4'd6, K_COMPLETE = 4'd7,
    K_DISCONNECT = 4'd8, K_TAKE = 4'd9
  } kind_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK = 3'd0, ST_NOT_ALLOWED = 3'd1, ST_AUTH = 3'd2,
    ST_NOT_INIT = 3'd3, ST_OVERFLOW = 3'd4, ST_NO_EVENT = 3'd5
  } status_e;

  typedef enum logic [EVK_W-1:0] {
    EV_EXPIRED = 2'd0, EV_CANCELLED = 2'd1, EV_PASSKEY = 2'd2, EV_COMPLETE = 2'd3
  } evkind_e;

  // pre-decoded request checks computed by the front end
  typedef struct packed {
    logic gen_zero;
    logic feat;
    logic auth_ok;
    logic pk_ok;
    logic secure;
  } cls_t;
endpackage

// ===== rtl/pwg_if.sv =====
// pwg_if: valid/ready channels for items and results
// depends on pwg_pkg
`timescale 1ns / 1ps
interface pwg_in_if #(parameter int TimeBits = 48, parameter int GenBits = 32);
  logic valid;
  logic ready;
  logic [pwg_pkg::KIND_W-1:0] kind;
  logic [TimeBits-1:0] now_ms;
  logic [pwg_pkg::CONN_W-1:0] conn_id;
  logic [GenBits-1:0] conn_generation;
  logic features_present;
  logic [pwg_pkg::BYTE_W-1:0] auth_flags;
  logic [pwg_pkg::BYTE_W-1:0] max_key_size;
  logic [pwg_pkg::BYTE_W-1:0] io_cap;
  logic [pwg_pkg::PK_IN_W-1:0] passkey;
  logic link_secure;
  modport source (output valid, kind, now_ms, conn_id, conn_generation, features_present,
                  auth_flags, max_key_size, io_cap, passkey, link_secure,
                  input ready);
  modport sink (input valid, kind, now_ms, conn_id, conn_generation, features_present,
                auth_flags, max_key_size, io_cap, passkey, link_secure,
                output ready);
endinterface

interface pwg_out_if #(parameter int GenBits = 32);
  logic valid;
  logic ready;
  logic [pwg_pkg::ST_W-1:0] status;
  logic window_is_open;
  logic bondable;
  logic disconnect_request;
  logic [pwg_pkg::CONN_W-1:0] disconnect_conn_id;
  logic [GenBits-1:0] disconnect_generation;
  logic event_valid;
  logic [pwg_pkg::EVK_W-1:0] event_kind;
  logic [pwg_pkg::PK_W-1:0] event_passkey;
  logic [GenBits-1:0] event_window_generation;
  logic [GenBits-1:0] event_conn_generation;
  modport source (output valid, status, window_is_open, bondable, disconnect_request,
                  disconnect_conn_id, disconnect_generation, event_valid, event_kind,
                  event_passkey, event_window_generation, event_conn_generation,
                  input ready);
  modport sink (input valid, status, window_is_open, bondable, disconnect_request,
                disconnect_conn_id, disconnect_generation, event_valid, event_kind,
                event_passkey, event_window_generation, event_conn_generation,
                output ready);
endinterface

// ===== rtl/pairing_window_gate_unit.sv =====
// pairing_window_gate_unit: top level, front classifier, queue and back engine
// depends on pwg_pkg, pwg_if, pwg_front, pwg_back
// flow: the back engine's steps are capture, execute, output and handshake; an
//   open or take that expires the window executes again, and take scans the event
//   queue before output; a new item is captured only once the result is taken
// the front queue takes up to two items while the back end is busy
// reset: asynchronous, clears all window, owner and queue state; config to defaults
`timescale 1ns / 1ps
module pairing_window_gate_unit #(
  parameter int QUEUE_DEPTH = 2,
  parameter int GENERATION_BITS = 32,
  parameter int TIME_BITS = 48
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [pwg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pwg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  pwg_in_if.sink in_if,
  pwg_out_if.source out_if
);
  import pwg_pkg::*;
  logic cv, cr;
  logic [KIND_W-1:0] ck;
  logic [TIME_BITS-1:0] cn;
  logic [CONN_W-1:0] cc;
  logic [GENERATION_BITS-1:0] cg;
  logic [PK_W-1:0] cp;
  cls_t cl;

  pwg_front #(.TimeBits(TIME_BITS), .GenBits(GENERATION_BITS), .FifoDepth(2)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .kind_i(in_if.kind), .now_i(in_if.now_ms), .conn_i(in_if.conn_id),
    .gen_i(in_if.conn_generation), .feat_i(in_if.features_present),
    .auth_i(in_if.auth_flags), .keysz_i(in_if.max_key_size), .io_i(in_if.io_cap),
    .pk_i(in_if.passkey), .secure_i(in_if.link_secure),
    .cmd_valid_o(cv), .cmd_ready_i(cr), .cmd_kind_o(ck), .cmd_now_o(cn),
    .cmd_conn_o(cc), .cmd_gen_o(cg), .cmd_pk_o(cp), .cmd_cls_o(cl)
  );

  pwg_back #(.TimeBits(TIME_BITS), .GenBits(GENERATION_BITS), .QueueDepth(QUEUE_DEPTH))
    u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_valid_i(cv), .cmd_ready_o(cr), .cmd_kind_i(ck), .cmd_now_i(cn),
    .cmd_conn_i(cc), .cmd_gen_i(cg), .cmd_pk_i(cp), .cmd_cls_i(cl),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .status_o(out_if.status), .win_o(out_if.window_is_open), .bond_o(out_if.bondable),
    .dreq_o(out_if.disconnect_request), .did_o(out_if.disconnect_conn_id),
    .dgen_o(out_if.disconnect_generation), .ev_valid_o(out_if.event_valid),
    .ev_kind_o(out_if.event_kind), .ev_pk_o(out_if.event_passkey),
    .ev_wg_o(out_if.event_window_generation), .ev_cg_o(out_if.event_conn_generation)
  );
endmodule

// ===== rtl/pwg_front.sv =====
// pwg_front: accepts items, classifies request fields, feeds a short queue
// depends on pwg_pkg
`timescale 1ns / 1ps
module pwg_front #(
  parameter int TimeBits = 48,
  parameter int GenBits = 32,
  parameter int FifoDepth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [pwg_pkg::KIND_W-1:0] kind_i,
  input  logic [TimeBits-1:0] now_i,
  input  logic [pwg_pkg::CONN_W-1:0] conn_i,
  input  logic [GenBits-1:0] gen_i,
  input  logic feat_i,
  input  logic [pwg_pkg::BYTE_W-1:0] auth_i,
  input  logic [pwg_pkg::BYTE_W-1:0] keysz_i,
  input  logic [pwg_pkg::BYTE_W-1:0] io_i,
  input  logic [pwg_pkg::PK_IN_W-1:0] pk_i,
  input  logic secure_i,
  output logic cmd_valid_o,
  input  logic cmd_ready_i,
  output logic [pwg_pkg::KIND_W-1:0] cmd_kind_o,
  output logic [TimeBits-1:0] cmd_now_o,
  output logic [pwg_pkg::CONN_W-1:0] cmd_conn_o,
  output logic [GenBits-1:0] cmd_gen_o,
  output logic [pwg_pkg::PK_W-1:0] cmd_pk_o,
  output pwg_pkg::cls_t cmd_cls_o
);
  import pwg_pkg::*;
  localparam int PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int CntW = $clog2(FifoDepth + 1);
  localparam int EntW = KIND_W + TimeBits + CONN_W + GenBits + PK_W + $bits(cls_t);

  logic [EntW-1:0] mem_q [FifoDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  cls_t cls;
  logic push, pop;

  always_comb begin
    cls.gen_zero = (gen_i == '0);
    cls.feat = feat_i;
    cls.auth_ok = ((auth_i & AUTH_SC_BIT) != '0) && (keysz_i == KEY_BYTES) &&
                  ((io_i == IO_KBD_ONLY) || (io_i == IO_KBD_DISPLAY));
    cls.pk_ok = (pk_i <= PASSKEY_LIMIT);
    cls.secure = secure_i;
  end

  assign in_ready_o = (cnt_q != CntW'(FifoDepth));
  assign push = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop = cmd_valid_o && cmd_ready_i;
  assign {cmd_kind_o, cmd_now_o, cmd_conn_o, cmd_gen_o, cmd_pk_o, cmd_cls_o} = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= {kind_i, now_i, conn_i, gen_i, pk_i[PK_W-1:0], cls};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_q + 1'b1;
      if (pop) rd_q <= (rd_q == PtrW'(FifoDepth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + CntW'(push) - CntW'(pop);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FifoDepth)) else $error("fifo count overrun");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !pop) else $error("pop from empty fifo");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1)) else $error("fifo count lost");
endmodule

// ===== rtl/pwg_back.sv =====
// pwg_back: window state, owner, event queue and result register
// depends on pwg_pkg
`timescale 1ns / 1ps
module pwg_back #(
  parameter int TimeBits = 48,
  parameter int GenBits = 32,
  parameter int QueueDepth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [pwg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pwg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  logic [pwg_pkg::KIND_W-1:0] cmd_kind_i,
  input  logic [TimeBits-1:0] cmd_now_i,
  input  logic [pwg_pkg::CONN_W-1:0] cmd_conn_i,
  input  logic [GenBits-1:0] cmd_gen_i,
  input  logic [pwg_pkg::PK_W-1:0] cmd_pk_i,
  input  pwg_pkg::cls_t cmd_cls_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic [pwg_pkg::ST_W-1:0] status_o,
  output logic win_o,
  output logic bond_o,
  output logic dreq_o,
  output logic [pwg_pkg::CONN_W-1:0] did_o,
  output logic [GenBits-1:0] dgen_o,
  output logic ev_valid_o,
  output logic [pwg_pkg::EVK_W-1:0] ev_kind_o,
  output logic [pwg_pkg::PK_W-1:0] ev_pk_o,
  output logic [GenBits-1:0] ev_wg_o,
  output logic [GenBits-1:0] ev_cg_o
);
  import pwg_pkg::*;
  localparam int QcW = $clog2(QueueDepth + 1);
  localparam int QiW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam logic [GenBits-1:0] GenMax = '1;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_OUT} state_e;
  state_e state_q;

  logic [LEN_W-1:0] len_q;
  logic [ATT_W-1:0] maxatt_q;
  logic init_q, own_q, bond_q;
  logic [GenBits-1:0] owg_q, wcnt_q, ogen_q, owng_q;
  logic [TimeBits-1:0] dl_q;
  logic [ATT_W-1:0] att_q;
  logic [CONN_W-1:0] oid_q;
  logic [QcW-1:0] qc_q;
  logic [EVK_W-1:0] qk_q [QueueDepth];
  logic [PK_W-1:0] qp_q [QueueDepth];
  logic [GenBits-1:0] qw_q [QueueDepth];
  logic [GenBits-1:0] qg_q [QueueDepth];
  logic [QiW-1:0] scan_q;

  logic [KIND_W-1:0] k_q;
  logic [TimeBits-1:0] now_q;
  logic [CONN_W-1:0] conn_q;
  logic [GenBits-1:0] gen_q;
  logic [PK_W-1:0] pk_q;
  cls_t cls_q;

  // expiry compare registered at capture so exec sees a short path
  logic due_q;

  logic [TimeBits:0] end_sum;
  logic [QiW-1:0] last;

  assign end_sum = {1'b0, now_q} + (TimeBits+1)'(len_q);
  assign last = QiW'(qc_q - 1'b1);

  assign cmd_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i) begin
    if (cmd_valid_i && cmd_ready_o) begin
      k_q <= cmd_kind_i;
      now_q <= cmd_now_i;
      conn_q <= cmd_conn_i;
      gen_q <= cmd_gen_i;
      pk_q <= cmd_pk_i;
      cls_q <= cmd_cls_i;
      due_q <= (cmd_now_i >= dl_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic own_match, winopen, cur, ok, same, valid;
    logic [QiW-1:0] i;
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q <= LEN_RESET;
      maxatt_q <= ATT_RESET;
      init_q <= 1'b0; own_q <= 1'b0; bond_q <= 1'b0;
      owg_q <= '0; wcnt_q <= '0; ogen_q <= '0; owng_q <= '0;
      dl_q <= '0; att_q <= '0; oid_q <= '0; qc_q <= '0; scan_q <= '0;
      out_valid_o <= 1'b0;
      status_o <= ST_OK; win_o <= 1'b0; bond_o <= 1'b0;
      dreq_o <= 1'b0; did_o <= '0; dgen_o <= '0;
      ev_valid_o <= 1'b0; ev_kind_o <= '0; ev_pk_o <= '0; ev_wg_o <= '0; ev_cg_o <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_WINDOW_LEN: len_q <= cfg_data_i[LEN_W-1:0];
          REG_MAX_ATT: maxatt_q <= cfg_data_i[ATT_W-1:0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            state_q <= S_EXEC;
            status_o <= ST_OK;
            dreq_o <= 1'b0; did_o <= '0; dgen_o <= '0;
            ev_valid_o <= 1'b0; ev_kind_o <= '0; ev_pk_o <= '0; ev_wg_o <= '0; ev_cg_o <= '0;
          end
        end
        S_EXEC: begin
          // expiry first for open, tick and take
          own_match = own_q && (oid_q == conn_q);
          winopen = init_q && (owg_q != '0) && !due_q;
          cur = own_match && (gen_q != '0) && (ogen_q == gen_q) && (owng_q == owg_q) && winopen;
          if ((k_q == K_OPEN || k_q == K_TICK || k_q == K_TAKE) &&
              (owg_q != '0) && due_q) begin
            qc_q <= QcW'(1); qk_q[0] <= EV_EXPIRED; qp_q[0] <= '0;
            qw_q[0] <= wcnt_q; qg_q[0] <= ogen_q;
            owg_q <= '0; dl_q <= '0; bond_q <= 1'b0;
            own_q <= 1'b0; oid_q <= '0; ogen_q <= '0; owng_q <= '0;
            if (own_q) begin
              dreq_o <= 1'b1; did_o <= oid_q; dgen_o <= ogen_q;
            end
            // open and take re-run with window now closed; due_q stays but owg is zero
            state_q <= (k_q == K_OPEN || k_q == K_TAKE) ? S_EXEC : S_OUT;
          end else if (k_q >= K_REQUEST && k_q <= K_DISCONNECT && !init_q) begin
            status_o <= ST_NOT_INIT;
            state_q <= S_OUT;
          end else begin
            state_q <= (k_q == K_TAKE) ? S_SCAN : S_OUT;
            case (k_q)
              K_INIT: if (!init_q) begin init_q <= 1'b1; bond_q <= 1'b0; end
              K_OPEN: begin
                if (!init_q) status_o <= ST_NOT_INIT;
                else if (!winopen) begin
                  if ((wcnt_q == GenMax) || end_sum[TimeBits]) status_o <= ST_OVERFLOW;
                  else begin
                    wcnt_q <= wcnt_q + 1'b1; owg_q <= wcnt_q + 1'b1;
                    dl_q <= end_sum[TimeBits-1:0]; att_q <= '0; bond_q <= 1'b1;
                    qc_q <= '0;
                  end
                end
              end
              K_CLOSE: begin
                if (owg_q != '0 || own_q) begin
                  qc_q <= QcW'(1); qk_q[0] <= EV_CANCELLED; qp_q[0] <= '0;
                  qw_q[0] <= wcnt_q; qg_q[0] <= ogen_q;
                end
                owg_q <= '0; dl_q <= '0; bond_q <= 1'b0;
                own_q <= 1'b0; oid_q <= '0; ogen_q <= '0; owng_q <= '0;
                if (own_q) begin dreq_o <= 1'b1; did_o <= oid_q; dgen_o <= ogen_q; end
              end
              K_TICK: ;
              K_REQUEST: begin
                if (cls_q.gen_zero || !cls_q.feat) status_o <= ST_NOT_ALLOWED;
                else if (!cls_q.auth_ok) status_o <= ST_AUTH;
                else begin
                  ok = winopen;
                  if (ok && own_q) begin
                    ok = (oid_q == conn_q) && (ogen_q == gen_q) && (owng_q == owg_q);
                  end else if (ok && att_q < maxatt_q) begin
                    qc_q <= '0; own_q <= 1'b1; oid_q <= conn_q; ogen_q <= gen_q;
                    owng_q <= owg_q; att_q <= att_q + 1'b1;
                  end else ok = 1'b0;
                  status_o <= ok ? ST_OK : ST_NOT_ALLOWED;
                end
              end
              K_PASSKEY, K_FAIL: begin
                ok = 1'b0;
                if (k_q == K_PASSKEY) begin
                  ok = cur && cls_q.pk_ok;
                  if (ok) begin
                    same = (qc_q != '0) && (qk_q[last] == EV_PASSKEY) && (qp_q[last] == pk_q);
                    if (!same) begin
                      if (qc_q >= QcW'(QueueDepth)) ok = 1'b0;
                      else begin
                        i = QiW'(qc_q);
                        qk_q[i] <= EV_PASSKEY; qp_q[i] <= pk_q;
                        qw_q[i] <= owg_q; qg_q[i] <= gen_q; qc_q <= qc_q + 1'b1;
                      end
                    end
                  end
                  if (!ok) status_o <= ST_NOT_ALLOWED;
                end
                if (!ok && own_match) begin
                  qc_q <= QcW'(1); qk_q[0] <= EV_CANCELLED; qp_q[0] <= '0;
                  qw_q[0] <= wcnt_q; qg_q[0] <= ogen_q;
                  own_q <= 1'b0; oid_q <= '0; ogen_q <= '0; owng_q <= '0;
                  if (att_q >= maxatt_q) begin owg_q <= '0; dl_q <= '0; bond_q <= 1'b0; end
                  dreq_o <= 1'b1; did_o <= conn_q; dgen_o <= ogen_q;
                end
              end
              K_COMPLETE: begin
                ok = cur && cls_q.secure;
                status_o <= ok ? ST_OK : ST_NOT_ALLOWED;
                if (own_match) begin
                  qc_q <= QcW'(1); qk_q[0] <= ok ? EV_COMPLETE : EV_CANCELLED; qp_q[0] <= '0;
                  qw_q[0] <= wcnt_q; qg_q[0] <= ogen_q;
                  owg_q <= '0; dl_q <= '0; bond_q <= 1'b0;
                  own_q <= 1'b0; oid_q <= '0; ogen_q <= '0; owng_q <= '0;
                  if (!ok) begin dreq_o <= 1'b1; did_o <= conn_q; dgen_o <= ogen_q; end
                end
              end
              K_DISCONNECT: begin
                if (own_match) begin
                  qc_q <= QcW'(1); qk_q[0] <= EV_CANCELLED; qp_q[0] <= '0;
                  qw_q[0] <= wcnt_q; qg_q[0] <= ogen_q;
                  own_q <= 1'b0; oid_q <= '0; ogen_q <= '0; owng_q <= '0;
                  if (att_q >= maxatt_q) begin owg_q <= '0; dl_q <= '0; bond_q <= 1'b0; end
                end
              end
              K_TAKE: begin
                status_o <= ST_NO_EVENT;
                scan_q <= '0;
              end
              default: status_o <= ST_NOT_ALLOWED;
            endcase
          end
        end
        S_SCAN: begin
          // one queue entry per cycle, front entry popped each time
          if (qc_q == '0) state_q <= S_OUT;
          else begin
            winopen = init_q && (owg_q != '0) && !due_q;
            valid = (qw_q[0] == wcnt_q);
            if (qk_q[0] == EV_PASSKEY)
              valid = valid && winopen && (owg_q == qw_q[0]) && own_q &&
                      (ogen_q == qg_q[0]) && (gen_q == qg_q[0]);
            for (int j = 0; j < QueueDepth - 1; j++) begin
              qk_q[j] <= qk_q[j+1]; qp_q[j] <= qp_q[j+1];
              qw_q[j] <= qw_q[j+1]; qg_q[j] <= qg_q[j+1];
            end
            qc_q <= qc_q - 1'b1;
            scan_q <= scan_q + 1'b1;
            if (valid) begin
              ev_valid_o <= 1'b1; ev_kind_o <= qk_q[0]; ev_pk_o <= qp_q[0];
              ev_wg_o <= qw_q[0]; ev_cg_o <= qg_q[0]; status_o <= ST_OK;
              state_q <= S_OUT;
            end else if (scan_q == QiW'(QueueDepth - 1)) state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_o) begin
            out_valid_o <= 1'b1;
            win_o <= init_q && (owg_q != '0) && (now_q < dl_q);
            bond_o <= bond_q;
          end else if (out_ready_i) begin
            out_valid_o <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    qc_q <= QcW'(QueueDepth)) else $error("event queue count overrun");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (state_q == S_OUT)) else $error("result shown outside output state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (own_q && owg_q != '0) |-> (owng_q == owg_q)) else $error("owner of stale window");
endmodule

// ===== bench/tb_pairing_window_gate_unit.sv =====
// tb_pairing_window_gate_unit: self-checking bench for the pairing window gate
// depends on pwg_pkg, pwg_if and pairing_window_gate_unit
`timescale 1ns / 1ps

typedef struct {
  logic [3:0]  kind;
  logic [47:0] now_ms;
  logic [7:0]  conn_id;
  logic [31:0] conn_gen;
  logic        feat;
  logic [7:0]  auth;
  logic [7:0]  keysz;
  logic [7:0]  io;
  logic [31:0] passkey;
  logic        secure;
} gate_item_t;

typedef struct {
  logic [2:0]  status;
  logic        win_open;
  logic        bondable;
  logic        disc_req;
  logic [7:0]  disc_id;
  logic [31:0] disc_gen;
  logic        ev_valid;
  logic [1:0]  ev_kind;
  logic [19:0] ev_pk;
  logic [31:0] ev_wg;
  logic [31:0] ev_cg;
} gate_result_t;

class gate_scoreboard;
  logic [23:0] win_len;
  logic [2:0]  att_max;
  bit          inited;
  logic [31:0] open_gen;
  logic [31:0] win_count;
  logic [47:0] deadline;
  logic [2:0]  attempts;
  bit          own_active;
  logic [7:0]  own_id;
  logic [31:0] own_gen;
  logic [31:0] own_wgen;
  bit          bond;
  int          evq_cnt;
  logic [1:0]  evq_kind [2];
  logic [19:0] evq_pk [2];
  logic [31:0] evq_wg [2];
  logic [31:0] evq_cg [2];
  bit          dreq;
  logic [7:0]  did;
  logic [31:0] dgen;
  gate_result_t expected_q [$];
  int          failures;

  function new();
    win_len = pwg_pkg::LEN_RESET;
    att_max = pwg_pkg::ATT_RESET;
    inited = 0; open_gen = 0; win_count = 0; deadline = 0; attempts = 0;
    bond = 0; failures = 0;
    detach();
    clear_events();
  endfunction

  function void set_reg(logic [0:0] idx, logic [23:0] val);
    if (idx == pwg_pkg::REG_WINDOW_LEN) win_len = val;
    else att_max = val[2:0];
  endfunction

  function bit is_open(logic [47:0] now);
    return inited && open_gen != 0 && now < deadline;
  endfunction

  function void clear_events();
    evq_cnt = 0;
    for (int i = 0; i < 2; i++) begin
      evq_kind[i] = 0; evq_pk[i] = 0; evq_wg[i] = 0; evq_cg[i] = 0;
    end
  endfunction

  function void post_terminal(logic [1:0] k, logic [31:0] cg);
    clear_events();
    evq_cnt = 1;
    evq_kind[0] = k;
    evq_wg[0] = win_count;
    evq_cg[0] = cg;
  endfunction

  function void shut();
    open_gen = 0; deadline = 0; bond = 0;
  endfunction

  function void detach();
    own_active = 0; own_id = 0; own_gen = 0; own_wgen = 0;
  endfunction

  function void ask_disc(logic [7:0] id, logic [31:0] g);
    dreq = 1; did = id; dgen = g;
  endfunction

  function void expire_check(logic [47:0] now);
    bit had;
    logic [7:0] id;
    logic [31:0] g;
    if (open_gen != 0 && now >= deadline) begin
      had = own_active; id = own_id; g = own_gen;
      post_terminal(pwg_pkg::EV_EXPIRED, g);
      shut();
      detach();
      if (had) ask_disc(id, g);
    end
  endfunction

  function bit owns(logic [7:0] c);
    return own_active && own_id == c;
  endfunction

  function void attempt_failed(logic [7:0] c);
    logic [31:0] g;
    if (owns(c)) begin
      g = own_gen;
      post_terminal(pwg_pkg::EV_CANCELLED, g);
      detach();
      if (attempts >= att_max) shut();
      ask_disc(c, g);
    end
  endfunction

  function bit owner_live(logic [7:0] c, logic [31:0] g, logic [47:0] now);
    return owns(c) && g != 0 && own_gen == g && own_wgen == open_gen && is_open(now);
  endfunction

  function void pop_event();
    evq_kind[0] = evq_kind[1]; evq_pk[0] = evq_pk[1];
    evq_wg[0] = evq_wg[1]; evq_cg[0] = evq_cg[1];
    evq_kind[1] = 0; evq_pk[1] = 0; evq_wg[1] = 0; evq_cg[1] = 0;
    evq_cnt--;
  endfunction

  // works out the result of one accepted item and stores it
  function void note_input(gate_item_t it);
    gate_result_t r;
    bit ok, same, had, success, valid;
    logic [7:0] id;
    logic [31:0] g, wg, cg;
    logic [1:0] k;
    logic [19:0] p;
    r = '{default: 0};
    r.status = pwg_pkg::ST_OK;
    dreq = 0; did = 0; dgen = 0;
    if (it.kind >= pwg_pkg::K_REQUEST && it.kind <= pwg_pkg::K_DISCONNECT && !inited) begin
      r.status = pwg_pkg::ST_NOT_INIT;
    end else begin
      case (it.kind)
        pwg_pkg::K_INIT: begin
          if (!inited) begin
            inited = 1; bond = 0;
          end
        end
        pwg_pkg::K_OPEN: begin
          expire_check(it.now_ms);
          if (!inited) begin
            r.status = pwg_pkg::ST_NOT_INIT;
          end else if (!is_open(it.now_ms)) begin
            if (win_count == 32'hFFFF_FFFF ||
                {1'b0, it.now_ms} > {1'b0, 48'hFFFF_FFFF_FFFF} - {25'd0, win_len}) begin
              r.status = pwg_pkg::ST_OVERFLOW;
            end else begin
              win_count++;
              open_gen = win_count;
              deadline = it.now_ms + win_len;
              attempts = 0;
              bond = 1;
              clear_events();
            end
          end
        end
        pwg_pkg::K_CLOSE: begin
          had = own_active; id = own_id; g = own_gen;
          if (open_gen != 0 || own_active) post_terminal(pwg_pkg::EV_CANCELLED, g);
          shut();
          detach();
          if (had) ask_disc(id, g);
        end
        pwg_pkg::K_TICK: expire_check(it.now_ms);
        pwg_pkg::K_REQUEST: begin
          if (it.conn_gen == 0 || !it.feat) begin
            r.status = pwg_pkg::ST_NOT_ALLOWED;
          end else if ((it.auth & pwg_pkg::AUTH_SC_BIT) == 0 || it.keysz != pwg_pkg::KEY_BYTES ||
                       (it.io != pwg_pkg::IO_KBD_ONLY && it.io != pwg_pkg::IO_KBD_DISPLAY)) begin
            r.status = pwg_pkg::ST_AUTH;
          end else begin
            ok = is_open(it.now_ms);
            if (ok && own_active) begin
              ok = own_id == it.conn_id && own_gen == it.conn_gen && own_wgen == open_gen;
            end else if (ok && attempts < att_max) begin
              clear_events();
              own_active = 1; own_id = it.conn_id; own_gen = it.conn_gen;
              own_wgen = open_gen;
              attempts = attempts + 3'd1;
            end else begin
              ok = 0;
            end
            r.status = ok ? pwg_pkg::ST_OK : pwg_pkg::ST_NOT_ALLOWED;
          end
        end
        pwg_pkg::K_PASSKEY: begin
          ok = owner_live(it.conn_id, it.conn_gen, it.now_ms) &&
               it.passkey <= pwg_pkg::PASSKEY_LIMIT;
          if (ok) begin
            same = evq_cnt > 0 && evq_kind[evq_cnt-1] == pwg_pkg::EV_PASSKEY &&
                   evq_pk[evq_cnt-1] == it.passkey[19:0];
            if (!same) begin
              if (evq_cnt >= 2) begin
                ok = 0;
              end else begin
                evq_kind[evq_cnt] = pwg_pkg::EV_PASSKEY;
                evq_pk[evq_cnt] = it.passkey[19:0];
                evq_wg[evq_cnt] = open_gen;
                evq_cg[evq_cnt] = it.conn_gen;
                evq_cnt++;
              end
            end
          end
          if (!ok) begin
            r.status = pwg_pkg::ST_NOT_ALLOWED;
            attempt_failed(it.conn_id);
          end
        end
        pwg_pkg::K_FAIL: attempt_failed(it.conn_id);
        pwg_pkg::K_COMPLETE: begin
          r.status = pwg_pkg::ST_NOT_ALLOWED;
          if (owns(it.conn_id)) begin
            success = owner_live(it.conn_id, it.conn_gen, it.now_ms) && it.secure;
            g = own_gen;
            post_terminal(success ? pwg_pkg::EV_COMPLETE : pwg_pkg::EV_CANCELLED, g);
            shut();
            detach();
            if (success) r.status = pwg_pkg::ST_OK;
            else ask_disc(it.conn_id, g);
          end
        end
        pwg_pkg::K_DISCONNECT: begin
          if (owns(it.conn_id)) begin
            post_terminal(pwg_pkg::EV_CANCELLED, own_gen);
            detach();
            if (attempts >= att_max) shut();
          end
        end
        pwg_pkg::K_TAKE: begin
          expire_check(it.now_ms);
          r.status = pwg_pkg::ST_NO_EVENT;
          for (int n = 0; n < 2; n++) begin
            if (evq_cnt == 0) break;
            k = evq_kind[0]; p = evq_pk[0]; wg = evq_wg[0]; cg = evq_cg[0];
            pop_event();
            valid = wg == win_count;
            if (k == pwg_pkg::EV_PASSKEY)
              valid = valid && is_open(it.now_ms) && open_gen == wg && own_active &&
                      own_gen == cg && it.conn_gen == cg;
            if (valid) begin
              r.ev_valid = 1; r.ev_kind = k; r.ev_pk = p; r.ev_wg = wg; r.ev_cg = cg;
              r.status = pwg_pkg::ST_OK;
              break;
            end
          end
        end
        default: r.status = pwg_pkg::ST_NOT_ALLOWED;
      endcase
    end
    r.win_open = is_open(it.now_ms);
    r.bondable = bond;
    r.disc_req = dreq;
    r.disc_id = did;
    r.disc_gen = dgen;
    expected_q.push_back(r);
  endfunction

  function void field_check(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      failures++;
    end
  endfunction

  function void check_result(gate_result_t a);
    gate_result_t e;
    if (expected_q.size() == 0) begin
      $error("result transfer with no expected result");
      failures++;
      return;
    end
    e = expected_q.pop_front();
    field_check("status", 64'(e.status), 64'(a.status));
    field_check("window_is_open", 64'(e.win_open), 64'(a.win_open));
    field_check("bondable", 64'(e.bondable), 64'(a.bondable));
    field_check("disconnect_request", 64'(e.disc_req), 64'(a.disc_req));
    field_check("disconnect_conn_id", 64'(e.disc_id), 64'(a.disc_id));
    field_check("disconnect_generation", 64'(e.disc_gen), 64'(a.disc_gen));
    field_check("event_valid", 64'(e.ev_valid), 64'(a.ev_valid));
    field_check("event_kind", 64'(e.ev_kind), 64'(a.ev_kind));
    field_check("event_passkey", 64'(e.ev_pk), 64'(a.ev_pk));
    field_check("event_window_generation", 64'(e.ev_wg), 64'(a.ev_wg));
    field_check("event_conn_generation", 64'(e.ev_cg), 64'(a.ev_cg));
  endfunction
endclass

module tb_pairing_window_gate_unit;
  import pwg_pkg::*;

  logic clk_i = 0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  pwg_in_if #(.TimeBits(48), .GenBits(32)) in_if ();
  pwg_out_if #(.GenBits(32)) out_if ();

  pairing_window_gate_unit u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .in_if(in_if), .out_if(out_if)
  );

  always #6 clk_i = ~clk_i;

  gate_scoreboard sb = new();
  bit quiet = 0;
  int stall_left = 0;
  logic [47:0] cur_now = 0;
  logic [23:0] cur_len = LEN_RESET;

  // result side: check each transfer, stall in random bursts
  always @(posedge clk_i) begin
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
      sb.check_result('{out_if.status, out_if.window_is_open, out_if.bondable,
                        out_if.disconnect_request, out_if.disconnect_conn_id,
                        out_if.disconnect_generation, out_if.event_valid, out_if.event_kind,
                        out_if.event_passkey, out_if.event_window_generation,
                        out_if.event_conn_generation});
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 16);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  task automatic send_item(gate_item_t it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.kind <= it.kind;
    in_if.now_ms <= it.now_ms;
    in_if.conn_id <= it.conn_id;
    in_if.conn_generation <= it.conn_gen;
    in_if.features_present <= it.feat;
    in_if.auth_flags <= it.auth;
    in_if.max_key_size <= it.keysz;
    in_if.io_cap <= it.io;
    in_if.passkey <= it.passkey;
    in_if.link_secure <= it.secure;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.note_input(it);
  endtask

  // write one register once all expected results are in and the block has settled
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
    if (idx == REG_WINDOW_LEN) cur_len = val;
  endtask

  function automatic gate_item_t make_item(logic [3:0] k, int c, int unsigned g);
    gate_item_t it;
    it.kind = k; it.now_ms = cur_now; it.conn_id = 8'(c); it.conn_gen = 32'(g);
    it.feat = 1; it.auth = AUTH_SC_BIT; it.keysz = KEY_BYTES; it.io = IO_KBD_ONLY;
    it.passkey = 32'd123456; it.secure = 1;
    return it;
  endfunction

  function automatic gate_item_t random_item();
    gate_item_t it;
    int r, step;
    r = $urandom_range(0, 99);
    if (r < 15) it.kind = K_OPEN;
    else if (r < 20) it.kind = K_CLOSE;
    else if (r < 28) it.kind = K_TICK;
    else if (r < 48) it.kind = K_REQUEST;
    else if (r < 63) it.kind = K_PASSKEY;
    else if (r < 70) it.kind = K_FAIL;
    else if (r < 78) it.kind = K_COMPLETE;
    else if (r < 83) it.kind = K_DISCONNECT;
    else if (r < 98) it.kind = K_TAKE;
    else if (r < 99) it.kind = K_INIT;
    else it.kind = 4'($urandom_range(10, 15));
    // time moves forward in small steps, with rare jumps anywhere
    step = (cur_len > 400) ? 133 : (cur_len / 3 + 2);
    if ($urandom_range(0, 39) == 0) cur_now = 48'({$urandom(), $urandom()});
    else cur_now = cur_now + $urandom_range(0, step);
    it.now_ms = cur_now;
    it.conn_id = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(1, 2)) : 8'($urandom());
    r = $urandom_range(0, 19);
    if (r == 0) it.conn_gen = 0;
    else if (r < 17) it.conn_gen = $urandom_range(1, 3);
    else it.conn_gen = $urandom();
    if ($urandom_range(0, 3) != 0) begin
      it.feat = 1;
      it.auth = 8'($urandom()) | AUTH_SC_BIT;
      it.keysz = KEY_BYTES;
      it.io = $urandom_range(0, 1) ? IO_KBD_ONLY : IO_KBD_DISPLAY;
    end else begin
      it.feat = 1'($urandom());
      it.auth = 8'($urandom());
      it.keysz = $urandom_range(0, 1) ? KEY_BYTES : 8'($urandom());
      it.io = 8'($urandom());
    end
    r = $urandom_range(0, 9);
    if (r < 3) it.passkey = $urandom_range(0, 1) ? 32'd7 : PASSKEY_LIMIT;
    else if (r < 8) it.passkey = $urandom_range(0, 999999);
    else it.passkey = $urandom();
    it.secure = ($urandom_range(0, 3) != 0);
    return it;
  endfunction

  initial begin
    logic [23:0] lens [5];
    logic [2:0]  atts [5];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.kind = '0;
    in_if.now_ms = '0;
    in_if.conn_id = '0;
    in_if.conn_generation = '0;
    in_if.features_present = 1'b0;
    in_if.auth_flags = '0;
    in_if.max_key_size = '0;
    in_if.io_cap = '0;
    in_if.passkey = '0;
    in_if.link_secure = 1'b0;
    out_if.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: calls before init, then one full pairing with the edge cases
    cur_now = 100;
    send_item(make_item(K_OPEN, 1, 5));
    send_item(make_item(K_REQUEST, 1, 5));
    send_item(make_item(K_TAKE, 1, 5));
    send_item(make_item(K_CLOSE, 1, 5));
    send_item(make_item(4'd15, 1, 5));
    send_item(make_item(K_INIT, 1, 5));
    send_item(make_item(K_OPEN, 1, 5));
    send_item(make_item(K_REQUEST, 1, 0));
    begin
      gate_item_t it;
      it = make_item(K_REQUEST, 1, 5); it.feat = 0; send_item(it);
      it = make_item(K_REQUEST, 1, 5); it.auth = 8'hF7; send_item(it);
      it = make_item(K_REQUEST, 1, 5); it.keysz = 8'd15; send_item(it);
      it = make_item(K_REQUEST, 1, 5); it.io = 8'h03; send_item(it);
      it = make_item(K_REQUEST, 1, 5); it.io = IO_KBD_DISPLAY; send_item(it);
      it = make_item(K_REQUEST, 2, 6); send_item(it);
      it = make_item(K_PASSKEY, 1, 5); it.passkey = PASSKEY_LIMIT + 1; send_item(it);
      send_item(make_item(K_REQUEST, 1, 5));
      it = make_item(K_PASSKEY, 1, 5); it.passkey = 0; send_item(it);
      send_item(it);
      it.passkey = PASSKEY_LIMIT; send_item(it);
      it.passkey = 32'hFFFF_FFFF; send_item(it);
      send_item(make_item(K_TAKE, 1, 5));
      send_item(make_item(K_REQUEST, 1, 5));
      send_item(make_item(K_COMPLETE, 1, 5));
      send_item(make_item(K_TAKE, 1, 5));
      cur_now = 48'hFFFF_FFFF_FFF0;
      send_item(make_item(K_OPEN, 8'hFF, 32'hFFFF_FFFF));
      cur_now = 1000;
      send_item(make_item(K_OPEN, 1, 5));
      send_item(make_item(K_REQUEST, 1, 5));
      cur_now = 70000;
      send_item(make_item(K_TICK, 1, 5));
      send_item(make_item(K_TAKE, 1, 5));
    end

    lens = '{24'd1, 24'hFF_FFFF, 24'd50, 24'd200, 24'($urandom_range(1, 500))};
    atts = '{3'd1, 3'd7, 3'd3, 3'd2, 3'($urandom_range(1, 7))};
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_WINDOW_LEN, lens[ph]);
      write_reg(REG_MAX_ATT, {21'd0, atts[ph]});
      if (ph == 4) quiet = 1;
      for (int n = 0; n < 85; n++) send_item(random_item());
    end
    in_if.valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.failures == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
